FILE: rtl/hsc_pkg.sv
package hsc_pkg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_CORR   = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_SECDED   = 1'b0,
        REG_DATA_LEN = 1'b1
    } reg_idx_t;

    localparam logic       SECDED_RST   = 1'b1;
    localparam logic [5:0] DATA_LEN_RST = 6'd57;

    typedef struct packed {
        logic       secded;
        logic [5:0] k;
        logic [5:0] n;
    } cfg_t;

    // smallest r with 2^r >= k + r + 1
    function automatic logic [2:0] check_count(input logic [5:0] k);
        logic [2:0] r;
        r = 3'd1;
        for (int i = 0; i < 6; i++) begin
            if ((7'd1 << r) < (7'(k) + 7'(r) + 7'd1)) begin
                r = r + 3'd1;
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/hsc_cfg.sv
module hsc_cfg #(
    parameter int MAX_DATA_BITS = 57
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output hsc_pkg::cfg_t     cfg
);

    logic       secded_reg;
    logic [5:0] data_len_reg;
    logic       wr_en;
    logic [5:0] k_eff;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secded_reg   <= hsc_pkg::SECDED_RST;
            data_len_reg <= hsc_pkg::DATA_LEN_RST;
        end else if (wr_en) begin
            case (hsc_pkg::reg_idx_t'(paddr[2]))
                hsc_pkg::REG_SECDED:   secded_reg   <= pwdata[0];
                hsc_pkg::REG_DATA_LEN: data_len_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (hsc_pkg::reg_idx_t'(paddr[2]))
            hsc_pkg::REG_SECDED:   prdata = {31'd0, secded_reg};
            hsc_pkg::REG_DATA_LEN: prdata = {26'd0, data_len_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (data_len_reg == 6'd0) begin
            k_eff = 6'd1;
        end else if (data_len_reg > 6'(MAX_DATA_BITS)) begin
            k_eff = 6'(MAX_DATA_BITS);
        end else begin
            k_eff = data_len_reg;
        end
    end

    assign cfg.secded = secded_reg;
    assign cfg.k      = k_eff;
    assign cfg.n      = k_eff + 6'(hsc_pkg::check_count(k_eff));

endmodule

FILE: rtl/hamming_secded_codec.sv
// channel | dir | tdata (low bit up)                            | tuser
// s_axis  | in  | word_in[63:0]                                 | cmd
// m_axis  | out | word_out[63:0], error_position[70:64], pad 0  | status
// config  | in  | apb, secded_mode at 0x0, data_len at 0x4      | -
//
// one beat per cycle while the result side is not stalled, each beat registered at the end of every stage
// stages: scatter and mask, syndrome and parity trees, check fill or correct and extract
// reset clears all stage valid bits, secded_mode to 1 and data_len to 57
// a stall holds up to three beats in the stages, ready falls only when all are full
module hamming_secded_codec #(
    parameter int MAX_DATA_BITS = 57
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // word_in
    input  logic        s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // word_out, error_position, pad
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NMAX  = MAX_DATA_BITS + int'(hsc_pkg::check_count(6'(MAX_DATA_BITS)));
    localparam int SYN_W = $clog2(NMAX + 1);

    hsc_pkg::cfg_t cfg;

    hsc_cfg #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic rdy1, rdy2, rdy3;

    // stage 1
    logic                v1_reg;
    hsc_pkg::cmd_t       cmd1_reg;
    logic [NMAX-1:0]     cw1_reg;
    logic                pin1_reg;
    logic [63:0]         kmask, nmask, datam;
    logic [NMAX-1:0]     scatter, cw1_next;
    logic                pin1_next;
    hsc_pkg::cmd_t       cmd_in;

    // stage 2
    logic                v2_reg;
    hsc_pkg::cmd_t       cmd2_reg;
    logic [NMAX-1:0]     cw2_reg;
    logic [SYN_W-1:0]    syn2_reg, syn2_next;
    logic                par2_reg, par2_next;

    // stage 3
    logic                v3_reg;
    logic [63:0]         word3_reg, word3_next;
    hsc_pkg::status_t    st3_reg, st3_next;
    logic [6:0]          pos3_reg, pos3_next;
    logic [NMAX-1:0]     cw_enc, cw_cor;
    logic [63:0]         flip;
    logic [MAX_DATA_BITS-1:0] ext;
    logic [6:0]          syn7;
    logic                par_enc;

    assign rdy3          = !v3_reg || m_axis_tready;
    assign rdy2          = !v2_reg || rdy3;
    assign rdy1          = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    assign cmd_in = hsc_pkg::cmd_t'(s_axis_tuser);
    assign kmask  = (64'd1 << cfg.k) - 64'd1;
    assign nmask  = (64'd1 << cfg.n) - 64'd1;
    assign datam  = s_axis_tdata & kmask;

    // data bits fill the non power of two positions in order
    genvar gp;
    generate
        for (gp = 1; gp <= NMAX; gp++) begin : g_pos
            if ((gp & (gp - 1)) == 0) begin : g_chk
                assign scatter[gp-1] = 1'b0;
            end else begin : g_dat
                assign scatter[gp-1]                  = datam[gp - $clog2(gp + 1) - 1];
                assign ext[gp - $clog2(gp + 1) - 1]   = cw_cor[gp-1];
            end
        end
    endgenerate

    always_comb begin
        if (cmd_in == hsc_pkg::CMD_ENCODE) begin
            cw1_next  = scatter;
            pin1_next = 1'b0;
        end else begin
            cw1_next  = s_axis_tdata[NMAX-1:0] & nmask[NMAX-1:0];
            pin1_next = cfg.secded & s_axis_tdata[cfg.n];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_axis_tvalid) begin
            cmd1_reg <= cmd_in;
            cw1_reg  <= cw1_next;
            pin1_reg <= pin1_next;
        end
    end

    always_comb begin
        syn2_next = '0;
        for (int i = 0; i < SYN_W; i++) begin
            for (int p = 1; p <= NMAX; p++) begin
                if (((p >> i) & 1) == 1) begin
                    syn2_next[i] = syn2_next[i] ^ cw1_reg[p-1];
                end
            end
        end
        par2_next = (^cw1_reg) ^ pin1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            cmd2_reg <= cmd1_reg;
            cw2_reg  <= cw1_reg;
            syn2_reg <= syn2_next;
            par2_reg <= par2_next;
        end
    end

    always_comb begin
        cw_enc = cw2_reg;
        for (int i = 0; i < SYN_W; i++) begin
            cw_enc[(1 << i) - 1] = cw2_reg[(1 << i) - 1] | syn2_reg[i];
        end
        par_enc = par2_reg ^ (^syn2_reg);
    end

    assign syn7 = 7'(syn2_reg);
    assign flip = 64'd1 << (syn7 - 7'd1);

    always_comb begin
        st3_next   = hsc_pkg::ST_OK;
        pos3_next  = 7'd0;
        cw_cor     = cw2_reg;
        if (cfg.secded && syn2_reg == '0) begin
            if (par2_reg) begin
                st3_next  = hsc_pkg::ST_CORR;
                pos3_next = 7'(cfg.n) + 7'd1;
            end
        end else if (cfg.secded && !par2_reg) begin
            st3_next = hsc_pkg::ST_DOUBLE;
        end else if (syn2_reg != '0) begin
            if (syn7 <= 7'(cfg.n)) begin
                st3_next  = hsc_pkg::ST_CORR;
                pos3_next = syn7;
                cw_cor    = cw2_reg ^ flip[NMAX-1:0];
            end else begin
                st3_next = hsc_pkg::ST_RANGE;
            end
        end
        if (cmd2_reg == hsc_pkg::CMD_ENCODE) begin
            st3_next   = hsc_pkg::ST_OK;
            pos3_next  = 7'd0;
            word3_next = 64'(cw_enc);
            word3_next[cfg.n] = word3_next[cfg.n] | (cfg.secded & par_enc);
        end else begin
            word3_next = 64'(ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            word3_reg <= word3_next;
            st3_reg   <= st3_next;
            pos3_reg  <= pos3_next;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {1'b0, pos3_reg, word3_reg};
    assign m_axis_tuser  = st3_reg;

endmodule

FILE: rtl/hsc_checker.sv
module hsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    a_no_pos_unless_corr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == hsc_pkg::ST_OK ||
            m_axis_tuser == hsc_pkg::ST_DOUBLE || m_axis_tuser == hsc_pkg::ST_RANGE)
            |-> m_axis_tdata[70:64] == 7'd0)
        else $error("error position without correction");

    a_corr_has_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == hsc_pkg::ST_CORR |->
            m_axis_tdata[70:64] != 7'd0 && m_axis_tdata[70:64] <= 7'd64)
        else $error("correction with bad position");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !m_axis_tdata[71])
        else $error("pad bit set");

endmodule

bind hamming_secded_codec hsc_checker u_hsc_checker (.*);

FILE: tb/hamming_secded_codec_tb.sv
module hamming_secded_codec_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DATA    = 57;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 60;
    localparam int LATENCY     = 3;

    typedef struct packed {
        logic [63:0]          word;
        hsc_pkg::status_t     status;
        logic [6:0]           pos;
    } codec_result_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;   // word_in
    logic        s_axis_tuser  = 1'b0; // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;         // word_out, error_position, pad
    logic [1:0]  m_axis_tuser;         // status
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    logic          cfg_secded = hsc_pkg::SECDED_RST;
    logic [5:0]    cfg_len    = hsc_pkg::DATA_LEN_RST;
    codec_result_t pending_results[$];
    int            errors        = 0;
    int            stall_cycles  = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_requests = 0;
    int            hold_served   = 0;
    int            hold_left     = 0;

    hamming_secded_codec dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 aclk = ~aclk;

    function automatic int codeword_len(input logic [5:0] dl);
        int k;
        int r;
        k = dl;
        if (k < 1) k = 1;
        if (k > MAX_DATA) k = MAX_DATA;
        r = 1;
        while ((1 << r) < k + r + 1) r++;
        return k + r;
    endfunction

    function automatic codec_result_t predict_codec(input bit dec, input logic [63:0] w,
                                                    input logic sd, input logic [5:0] dl);
        codec_result_t res;
        logic [63:0]   cw;
        int            n;
        int            j;
        int            syn;
        int            par;
        n   = codeword_len(dl);
        res = '{word: '0, status: hsc_pkg::ST_OK, pos: '0};
        cw  = '0;
        syn = 0;
        par = 0;
        j   = 0;
        if (!dec) begin
            for (int p = 1; p <= n; p++) begin
                if ((p & (p - 1)) == 0) continue;
                if (w[j]) begin
                    cw[p-1] = 1'b1;
                    syn ^= p;
                end
                j++;
            end
            for (int p = 1; p <= n; p <<= 1) begin
                if ((syn & p) != 0) cw[p-1] = 1'b1;
            end
            if (sd) cw[n] = ^cw;
            res.word = cw;
        end else begin
            for (int p = 1; p <= n; p++) begin
                if (w[p-1]) begin
                    syn ^= p;
                    par ^= 1;
                end
            end
            if (sd) par ^= int'(w[n]);
            cw = w;
            if (sd && syn == 0) begin
                if (par != 0) begin
                    res.status = hsc_pkg::ST_CORR;
                    res.pos    = 7'(n + 1);
                end
            end else if (sd && par == 0) begin
                res.status = hsc_pkg::ST_DOUBLE;
            end else if (syn != 0) begin
                if (syn <= n) begin
                    res.status = hsc_pkg::ST_CORR;
                    res.pos    = 7'(syn);
                    cw[syn-1]  = ~cw[syn-1];
                end else begin
                    res.status = hsc_pkg::ST_RANGE;
                end
            end
            for (int p = 1; p <= n; p++) begin
                if ((p & (p - 1)) == 0) continue;
                res.word[j] = cw[p-1];
                j++;
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] encode_word(input logic [63:0] data);
        codec_result_t res;
        res = predict_codec(1'b0, data, cfg_secded, cfg_len);
        return res.word;
    endfunction

    function automatic void note_failure(input string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    // predict on every input beat, check every result beat
    always @(posedge aclk) begin
        codec_result_t want;
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(predict_codec(s_axis_tuser == hsc_pkg::CMD_DECODE,
                                                        s_axis_tdata, cfg_secded, cfg_len));
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    note_failure($sformatf("unexpected result beat word %h status %0d pos %0d",
                                           m_axis_tdata[63:0], m_axis_tuser,
                                           m_axis_tdata[70:64]));
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[63:0] !== want.word)
                        note_failure($sformatf("word_out exp %h got %h",
                                               want.word, m_axis_tdata[63:0]));
                    if (m_axis_tuser !== want.status)
                        note_failure($sformatf("status exp %0d got %0d",
                                               want.status, m_axis_tuser));
                    if (m_axis_tdata[70:64] !== want.pos)
                        note_failure($sformatf("error_position exp %0d got %0d",
                                               want.pos, m_axis_tdata[70:64]));
                end
            end
        end
    end

    // result side: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("** hamming_secded_codec: FAILED **");
        $finish;
    end

    task automatic send_item(input hsc_pkg::cmd_t cmd, input logic [63:0] word);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = word;
        s_axis_tuser  = cmd;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic apb_write(input hsc_pkg::reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == hsc_pkg::REG_SECDED) cfg_secded = value[0];
        else cfg_len = value[5:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_check_read(input hsc_pkg::reg_idx_t idx);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == hsc_pkg::REG_SECDED && prdata[0] !== cfg_secded)
            note_failure($sformatf("secded_mode read exp %0d got %0d", cfg_secded, prdata[0]));
        if (idx == hsc_pkg::REG_DATA_LEN && prdata[5:0] !== cfg_len)
            note_failure($sformatf("data_len read exp %0d got %0d", cfg_len, prdata[5:0]));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic configure(input logic sd, input logic [5:0] dl);
        drain_results();
        apb_write(hsc_pkg::REG_SECDED, {31'd0, sd});
        apb_write(hsc_pkg::REG_DATA_LEN, {26'd0, dl});
        apb_check_read(hsc_pkg::REG_SECDED);
        apb_check_read(hsc_pkg::REG_DATA_LEN);
    endtask

    task automatic send_random_item();
        logic [63:0] w;
        logic [63:0] junk;
        int          width;
        int          mode;
        int          a;
        int          b;
        width = codeword_len(cfg_len) + int'(cfg_secded);
        w     = {$urandom, $urandom};
        junk  = {$urandom, $urandom};
        mode  = $urandom_range(99);
        if (mode < 25) begin
            send_item(hsc_pkg::CMD_ENCODE, w);
        end else begin
            // mostly valid codewords with zero, one or two flipped bits
            if (mode < 90) begin
                w = encode_word(w);
                a = $urandom_range(width - 1);
                b = (a + 1 + $urandom_range(width - 2)) % width;
                if (mode >= 35) w[a] = ~w[a];
                if (mode >= 70) w[b] = ~w[b];
                if (width < 64 && $urandom_range(1) == 1)
                    w |= junk & ~((64'd1 << width) - 64'd1);
            end
            send_item(hsc_pkg::CMD_DECODE, w);
        end
    endtask

    task automatic test_register_reset();
        apb_check_read(hsc_pkg::REG_SECDED);
        apb_check_read(hsc_pkg::REG_DATA_LEN);
    endtask

    task automatic test_directed();
        logic [63:0] cw;
        send_item(hsc_pkg::CMD_ENCODE, 64'd0);
        send_item(hsc_pkg::CMD_ENCODE, '1);
        send_item(hsc_pkg::CMD_ENCODE, 64'h0155_5555_5555_5555);
        cw = encode_word(64'h0155_5555_5555_5555);
        send_item(hsc_pkg::CMD_DECODE, cw);
        send_item(hsc_pkg::CMD_DECODE, cw ^ (64'd1 << 2));
        send_item(hsc_pkg::CMD_DECODE, cw ^ (64'd1 << 0));
        send_item(hsc_pkg::CMD_DECODE, cw ^ (64'd1 << 31));
        send_item(hsc_pkg::CMD_DECODE, cw ^ (64'd1 << 62));
        send_item(hsc_pkg::CMD_DECODE, cw ^ (64'd1 << 63));
        send_item(hsc_pkg::CMD_DECODE, cw ^ (64'd1 << 5) ^ (64'd1 << 40));
        send_item(hsc_pkg::CMD_DECODE, '1);
        send_item(hsc_pkg::CMD_DECODE, 64'd0);
        // plain correction, short word so the syndrome can run past the end
        configure(1'b0, 6'd2);
        send_item(hsc_pkg::CMD_ENCODE, 64'hffff_ffff_ffff_fffd);
        send_item(hsc_pkg::CMD_DECODE, 64'h0000_0000_0000_000c);
        cw = encode_word(64'd2);
        send_item(hsc_pkg::CMD_DECODE, cw);
        send_item(hsc_pkg::CMD_DECODE, cw ^ 64'd4);
        send_item(hsc_pkg::CMD_DECODE, cw | 64'hffff_ffff_ffff_ffe0);
        configure(1'b1, 6'd0);
        send_item(hsc_pkg::CMD_ENCODE, 64'd1);
        cw = encode_word(64'd1);
        send_item(hsc_pkg::CMD_DECODE, cw ^ (64'd1 << 3));
        send_item(hsc_pkg::CMD_DECODE, cw ^ 64'd3);
        drain_results();
    endtask

    task automatic test_backpressure();
        configure(1'b1, 6'd57);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        repeat (30) send_random_item();
        drain_results();
        repeat (10) send_random_item();
        drain_results();
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
        logic [5:0] lens[8];
        logic       modes[8];
        lens  = '{6'd57, 6'd57, 6'd0, 6'd1, 6'd2, 6'd63, 6'($urandom_range(63)),
                  6'($urandom_range(1, 26))};
        modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        for (int c = 0; c < 8; c++) begin
            configure(modes[c], lens[c]);
            send_idle_pct = sender_idle;
            recv_idle_pct = receiver_idle;
            repeat (75) send_random_item();
        end
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_register_reset();
        test_directed();
        test_backpressure();
        test_random_traffic(12, 75);
        test_random_traffic(75, 12);
        test_random_traffic(0, 0);
        drain_results();
        repeat (8) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("** hamming_secded_codec: PASSED **");
        end else begin
            $display("** hamming_secded_codec: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/hsc_pkg.sv
rtl/hsc_cfg.sv
rtl/hamming_secded_codec.sv
rtl/hsc_checker.sv
tb/hamming_secded_codec_tb.sv
